FILE: sv/cau_pkg.sv
package cau_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam int IO_WIDTH       = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 2;

  // classified item passed from front to back
  typedef struct packed {
    op_t                 op;
    logic                dbz;
    logic [IO_WIDTH-1:0] a_re;
    logic [IO_WIDTH-1:0] a_im;
    logic [IO_WIDTH-1:0] b_re;
    logic [IO_WIDTH-1:0] b_im;
  } cmd_t;

endpackage

FILE: sv/complex_arith_unit.sv
// complex number alu: add, subtract, multiply and divide on signed fixed point
// input channel: drive operation and the four operand parts, raise push; the
//   item is taken on a clock edge with push high and full low
// result channel: while empty is low the oldest result sits on res_re, res_im,
//   overflow and div_by_zero; raise pop to take it
// path: an accepted item passes the product, sum and scaling registers, one
//   restoring divider stage per quotient bit and the output register before
//   empty falls
// throughput: one item per cycle while the output register is free or popped; every operation takes the same path
// a stalled receiver freezes the whole back pipeline; the two-entry input
//   queue absorbs items until full rises, and no item is lost
// reset clears the input queue and pipeline valid flags; nothing else is kept
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 operation,
  input  logic signed [IO_WIDTH-1:0] a_re,
  input  logic signed [IO_WIDTH-1:0] a_im,
  input  logic signed [IO_WIDTH-1:0] b_re,
  input  logic signed [IO_WIDTH-1:0] b_im,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [IO_WIDTH-1:0] res_re,
  output logic signed [IO_WIDTH-1:0] res_im,
  output logic                       overflow,
  output logic                       div_by_zero
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .empty       (empty),
    .pop         (pop),
    .res_re      (res_re),
    .res_im      (res_im),
    .overflow    (overflow),
    .div_by_zero (div_by_zero)
  );

endmodule

FILE: sv/cau_front.sv
module cau_front import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [IO_WIDTH-1:0] a_re,
  input  logic [IO_WIDTH-1:0] a_im,
  input  logic [IO_WIDTH-1:0] b_re,
  input  logic [IO_WIDTH-1:0] b_im,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output cmd_t                cmd
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem [0:QUEUE_DEPTH-1];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          wr_en;
  logic          rd_en;
  cmd_t          item;

  // classify the incoming item
  always_comb begin
    item.op   = op_t'(operation);
    item.dbz  = (op_t'(operation) == OP_DIV) && (b_re[DATA_WIDTH-1:0] == '0) &&
                (b_im[DATA_WIDTH-1:0] == '0);
    item.a_re = a_re;
    item.a_im = a_im;
    item.b_re = b_re;
    item.b_im = b_im;
  end

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_valid && cmd_ready;
  assign cmd       = mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/cau_div_lane.sv
module cau_div_lane import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*DATA_WIDTH:0]     in_rem,
  input  logic [DATA_WIDTH-1:0]     in_low,
  input  logic [2*DATA_WIDTH-1:0]   in_den,
  output logic [DATA_WIDTH-1:0]     quo
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = 2 * W + 1;

  logic [RW-1:0]  rem_q [1:W];
  logic [W-1:0]   low_q [1:W];
  logic [2*W-1:0] den_q [1:W];
  logic [W-1:0]   quo_q [1:W];

  // one restoring step per stage
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [RW-1:0]  r_in;
    logic [W-1:0]   l_in;
    logic [2*W-1:0] d_in;
    logic [W-1:0]   q_in;
    logic [RW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign r_in = in_rem;
      assign l_in = in_low;
      assign d_in = in_den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k];
      assign l_in = low_q[k];
      assign d_in = den_q[k];
      assign q_in = quo_q[k];
    end

    assign trial = {r_in[RW-2:0], l_in[W-1]};
    assign ge    = (trial >= RW'(d_in));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? trial - RW'(d_in) : trial;
        low_q[k+1] <= {l_in[W-2:0], 1'b0};
        den_q[k+1] <= d_in;
        quo_q[k+1] <= {q_in[W-2:0], ge};
      end
    end
  end

  assign quo = quo_q[W];

endmodule

FILE: sv/cau_back.sv
module cau_back import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  cmd_t                       cmd,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [IO_WIDTH-1:0] res_re,
  output logic signed [IO_WIDTH-1:0] res_im,
  output logic                       overflow,
  output logic                       div_by_zero
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + F + 2;
  localparam int NW  = SW + F;
  localparam int RW  = 2 * W + 1;
  localparam int SBW = 2 * W + 6;

  logic en;
  logic ovalid;

  // stage 1: operands and products
  logic                v1;
  op_t                 op1;
  logic                dbz1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [W-1:0] ar0, ai0, br0, bi0;

  // stage 2: exact sums as sign and magnitude
  logic          v2;
  op_t           op2;
  logic          dbz2;
  logic          neg_re2, neg_im2;
  logic [SW-1:0] mag_re2, mag_im2;
  logic [PW-1:0] den2;
  logic signed [SW-1:0] s_re, s_im;
  logic signed [SW-1:0] ar_x, ai_x, br_x, bi_x;

  // stage 3: scaled result or divider setup
  logic          v3;
  logic          div3, dbz3;
  logic          neg_re3, neg_im3, big_re3, big_im3;
  logic [W-1:0]  qm_re3, qm_im3;
  logic [RW-1:0] rem_re3, rem_im3;
  logic [W-1:0]  low_re3, low_im3;
  logic [PW-1:0] den3;
  logic [SW-1:0] sh_re, sh_im;
  logic [NW-1:0] n_re, n_im, dlim;

  // divider lanes and sideband delay line
  logic [W-1:0]   quo_re, quo_im;
  logic           sv [1:W];
  logic [SBW-1:0] sb [1:W];
  logic           f_dbz, f_div, f_nre, f_nim, f_bre, f_bim;
  logic [W-1:0]   f_qre, f_qim;
  logic [W:0]     sat_re, sat_im;

  // output register
  logic signed [IO_WIDTH-1:0] res_re_q, res_im_q;
  logic                       ovf_q, dbz_q;

  // saturate sign and magnitude into W bits, msb is the overflow flag
  function automatic logic [W:0] sat_part(input logic neg, input logic big,
                                          input logic [W-1:0] q);
    logic [W:0] qx;
    logic [W:0] lim;
    logic [W:0] r;
    qx  = {1'b0, q};
    lim = (W+1)'(1) << (W - 1);
    if (!neg) begin
      if (big || qx >= lim) begin
        r = {1'b1, W'(lim - 1'b1)};
      end else begin
        r = {1'b0, q};
      end
    end else begin
      if (big || qx > lim) begin
        r = {1'b1, W'(lim)};
      end else begin
        r = {1'b0, W'((W+1)'(0) - qx)};
      end
    end
    return r;
  endfunction

  // whole back pipeline advances when the output slot frees up
  assign en        = !ovalid || pop;
  assign cmd_ready = en;

  assign ar0 = cmd.a_re[W-1:0];
  assign ai0 = cmd.a_im[W-1:0];
  assign br0 = cmd.b_re[W-1:0];
  assign bi0 = cmd.b_im[W-1:0];

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= cmd.op;
      dbz1 <= cmd.dbz;
      ar1  <= ar0;
      ai1  <= ai0;
      br1  <= br0;
      bi1  <= bi0;
      p_rr <= ar0 * br0;
      p_ii <= ai0 * bi0;
      p_ri <= ar0 * bi0;
      p_ir <= ai0 * br0;
      p_bb <= br0 * br0;
      p_cc <= bi0 * bi0;
    end
  end

  // combine products or scaled operands per operation
  always_comb begin
    ar_x = SW'(ar1) <<< F;
    ai_x = SW'(ai1) <<< F;
    br_x = SW'(br1) <<< F;
    bi_x = SW'(bi1) <<< F;
    case (op1)
      OP_ADD: begin
        s_re = ar_x + br_x;
        s_im = ai_x + bi_x;
      end
      OP_SUB: begin
        s_re = ar_x - br_x;
        s_im = ai_x - bi_x;
      end
      OP_MUL: begin
        s_re = SW'(p_rr) - SW'(p_ii);
        s_im = SW'(p_ri) + SW'(p_ir);
      end
      default: begin
        s_re = SW'(p_rr) + SW'(p_ii);
        s_im = SW'(p_ir) - SW'(p_ri);
      end
    endcase
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2     <= op1;
      dbz2    <= dbz1;
      neg_re2 <= s_re[SW-1];
      neg_im2 <= s_im[SW-1];
      mag_re2 <= s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
      mag_im2 <= s_im[SW-1] ? SW'(-s_im) : SW'(s_im);
      den2    <= PW'($unsigned(p_bb)) + PW'($unsigned(p_cc));
    end
  end

  // floor scaling for add, subtract, multiply; numerator setup for divide
  always_comb begin
    sh_re = neg_re2 ? (mag_re2 + ((SW'(1) << F) - 1'b1)) >> F : mag_re2 >> F;
    sh_im = neg_im2 ? (mag_im2 + ((SW'(1) << F) - 1'b1)) >> F : mag_im2 >> F;
    n_re  = NW'(mag_re2) << F;
    n_im  = NW'(mag_im2) << F;
    dlim  = NW'(den2) << W;
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div3 <= (op2 == OP_DIV);
      dbz3 <= dbz2;
      den3 <= den2;
      rem_re3 <= RW'(n_re >> W);
      rem_im3 <= RW'(n_im >> W);
      low_re3 <= n_re[W-1:0];
      low_im3 <= n_im[W-1:0];
      if (op2 == OP_DIV) begin
        big_re3 <= (n_re >= dlim);
        big_im3 <= (n_im >= dlim);
        neg_re3 <= neg_re2;
        neg_im3 <= neg_im2;
      end else begin
        big_re3 <= (sh_re >> W) != '0;
        big_im3 <= (sh_im >> W) != '0;
        neg_re3 <= neg_re2 && (sh_re != '0);
        neg_im3 <= neg_im2 && (sh_im != '0);
      end
      qm_re3 <= sh_re[W-1:0];
      qm_im3 <= sh_im[W-1:0];
    end
  end

  cau_div_lane #(.DATA_WIDTH(DATA_WIDTH)) u_lane_re (
    .clk    (clk),
    .en     (en),
    .in_rem (rem_re3),
    .in_low (low_re3),
    .in_den (den3),
    .quo    (quo_re)
  );

  cau_div_lane #(.DATA_WIDTH(DATA_WIDTH)) u_lane_im (
    .clk    (clk),
    .en     (en),
    .in_rem (rem_im3),
    .in_low (low_im3),
    .in_den (den3),
    .quo    (quo_im)
  );

  // sideband follows the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= W; k++) begin
        sv[k] <= 1'b0;
      end
    end else if (en) begin
      sv[1] <= v3;
      for (int k = 1; k < W; k++) begin
        sv[k+1] <= sv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[1] <= {dbz3, div3, neg_re3, neg_im3, big_re3, big_im3, qm_re3, qm_im3};
      for (int k = 1; k < W; k++) begin
        sb[k+1] <= sb[k];
      end
    end
  end

  // final saturation
  always_comb begin
    {f_dbz, f_div, f_nre, f_nim, f_bre, f_bim, f_qre, f_qim} = sb[W];
    if (f_div) begin
      f_nre = f_nre && (quo_re != '0);
      f_nim = f_nim && (quo_im != '0);
      f_qre = quo_re;
      f_qim = quo_im;
    end
    sat_re = sat_part(f_nre, f_bre, f_qre);
    sat_im = sat_part(f_nim, f_bim, f_qim);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= sv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_dbz) begin
        res_re_q <= '0;
        res_im_q <= '0;
        ovf_q    <= 1'b0;
        dbz_q    <= 1'b1;
      end else begin
        res_re_q <= IO_WIDTH'($signed(sat_re[W-1:0]));
        res_im_q <= IO_WIDTH'($signed(sat_im[W-1:0]));
        ovf_q    <= sat_re[W] || sat_im[W];
        dbz_q    <= 1'b0;
      end
    end
  end

  assign empty       = !ovalid;
  assign res_re      = res_re_q;
  assign res_im      = res_im_q;
  assign overflow    = ovf_q;
  assign div_by_zero = dbz_q;

endmodule
